/* hdl/symidx_pkg.sv */
// shared constants for the symmetric index fold core
package symidx_pkg;

   // number of index fields carried on the channels
   localparam int MAX_DIMS = 6;
   // width of the same-group mask register
   localparam int MASK_BITS = MAX_DIMS - 1;
   // register stages of the sorting network, two transposition phases each
   localparam int SORT_STAGES = MAX_DIMS / 2;
   // total register stages, sort stages plus the output stage
   localparam int PIPE_STAGES = SORT_STAGES + 1;

endpackage

/* hdl/symmetric_index_fold_core.sv */
// symmetric index fold core: group sort and left justification of an index tuple
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+----------------------------------------
//  req     | in  | req_tvalid / req_tready   | req_tdata: index_0 .. index_5
//  rsp     | out | rsp_tvalid / rsp_tready   | rsp_tdata: packed_0 .. packed_5
//  csr     | in  | csr_valid / csr_ready     | csr_wdata: same_group_mask
//
// four register stages: three of the odd-even transposition network (two compare-exchange
// phases each) and one that forms the differences; a req word passes the sort stages and
// the difference stage before rsp is valid; one word per cycle flows unless rsp stalls.
// reset clears every stage valid bit and the mask (no groups); payload is not reset.
// each stage holds its word only while the stage after it is full and stalled, so a
// bubble anywhere lets req_tready stay high while a finished word waits on rsp.
module symmetric_index_fold_core #(
   parameter int NUM_DIMS = 6,
   parameter int INDEX_BITS = 10,
   localparam int DATA_W = ((symidx_pkg::MAX_DIMS * INDEX_BITS + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [DATA_W-1:0]                req_tdata,   // index_0 .. index_5, zero fill
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [DATA_W-1:0]                rsp_tdata,   // packed_0 .. packed_5, zero fill
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [symidx_pkg::MASK_BITS-1:0] csr_wdata    // same_group_mask
);
   import symidx_pkg::*;

   localparam int PAD_W = DATA_W - MAX_DIMS * INDEX_BITS;

   logic [MASK_BITS-1:0]  mask_ff;
   // link_w[k]: dimension k sorts together with dimension k-1
   logic [MAX_DIMS-1:0]   link_w;

   logic [INDEX_BITS-1:0] entry_w [MAX_DIMS];
   logic [INDEX_BITS-1:0] src_w   [SORT_STAGES][MAX_DIMS];
   logic [INDEX_BITS-1:0] mid_w   [SORT_STAGES][MAX_DIMS];
   logic [INDEX_BITS-1:0] srt_in  [SORT_STAGES][MAX_DIMS];
   logic [INDEX_BITS-1:0] srt_ff  [SORT_STAGES][MAX_DIMS];
   logic [INDEX_BITS-1:0] out_in  [MAX_DIMS];
   logic [INDEX_BITS-1:0] out_ff  [MAX_DIMS];

   logic [PIPE_STAGES-1:0] vld_ff;
   logic [PIPE_STAGES:0]   rdy_w;

   // configuration register, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else if (csr_valid) begin
         mask_ff <= csr_wdata;
      end
   end

   // mask bits at or above NUM_DIMS-1 have no dimension to link
   always_comb begin
      link_w = '0;
      for (int k = 1; k < MAX_DIMS; k++) begin
         link_w[k] = (k < NUM_DIMS) && mask_ff[k-1];
      end
   end

   // unpack the request word, dimensions past NUM_DIMS enter as zero
   always_comb begin
      for (int k = 0; k < MAX_DIMS; k++) begin
         entry_w[k] = (k < NUM_DIMS) ? req_tdata[k*INDEX_BITS +: INDEX_BITS] : '0;
      end
   end

   // odd-even transposition sort restricted to linked neighbors; every run gets at
   // least its own length in phases, which sorts it whatever parity it starts on
   always_comb begin
      for (int k = 0; k < MAX_DIMS; k++) begin
         src_w[0][k] = entry_w[k];
      end
      for (int s = 1; s < SORT_STAGES; s++) begin
         for (int k = 0; k < MAX_DIMS; k++) begin
            src_w[s][k] = srt_ff[s-1][k];
         end
      end
      for (int s = 0; s < SORT_STAGES; s++) begin
         // even phase: pairs (0,1) (2,3) (4,5)
         mid_w[s] = src_w[s];
         for (int i = 0; i < MAX_DIMS - 1; i++) begin
            if ((i % 2) == 0 && link_w[i+1] && (src_w[s][i] > src_w[s][i+1])) begin
               mid_w[s][i]   = src_w[s][i+1];
               mid_w[s][i+1] = src_w[s][i];
            end
         end
         // odd phase: pairs (1,2) (3,4)
         srt_in[s] = mid_w[s];
         for (int i = 0; i < MAX_DIMS - 1; i++) begin
            if ((i % 2) == 1 && link_w[i+1] && (mid_w[s][i] > mid_w[s][i+1])) begin
               srt_in[s][i]   = mid_w[s][i+1];
               srt_in[s][i+1] = mid_w[s][i];
            end
         end
      end
   end

   // left justification: linked dimensions keep the step from their sorted neighbor
   always_comb begin
      out_in[0] = srt_ff[SORT_STAGES-1][0];
      for (int k = 1; k < MAX_DIMS; k++) begin
         if (k >= NUM_DIMS) begin
            out_in[k] = '0;
         end else if (link_w[k]) begin
            out_in[k] = srt_ff[SORT_STAGES-1][k] - srt_ff[SORT_STAGES-1][k-1];
         end else begin
            out_in[k] = srt_ff[SORT_STAGES-1][k];
         end
      end
   end

   // a stage may load when it is empty or its word moves on this cycle
   always_comb begin
      rdy_w[PIPE_STAGES] = rsp_tready;
      for (int s = PIPE_STAGES - 1; s >= 0; s--) begin
         rdy_w[s] = !vld_ff[s] || rdy_w[s+1];
      end
   end

   assign req_tready = rdy_w[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy_w[0]) begin
            vld_ff[0] <= req_tvalid;
         end
         for (int s = 1; s < PIPE_STAGES; s++) begin
            if (rdy_w[s]) begin
               vld_ff[s] <= vld_ff[s-1];
            end
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      for (int s = 0; s < SORT_STAGES; s++) begin
         if (rdy_w[s]) begin
            srt_ff[s] <= srt_in[s];
         end
      end
      if (rdy_w[PIPE_STAGES-1]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = vld_ff[PIPE_STAGES-1];

   // pack the result word, lowest field in the lowest bits
   for (genvar k = 0; k < MAX_DIMS; k++) begin : g_pack
      assign rsp_tdata[k*INDEX_BITS +: INDEX_BITS] = out_ff[k];
   end
   if (PAD_W > 0) begin : g_pad
      assign rsp_tdata[DATA_W-1 -: PAD_W] = '0;
   end

   // checks

   // a full pipeline with a stalled output takes no new word
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      ((&vld_ff) && !rsp_tready) |-> !req_tready)
      else $error("request taken while pipeline full and stalled");

   // a word leaving the sort network is ascending within every run
   for (genvar k = 1; k < MAX_DIMS; k++) begin : g_chk_sorted
      a_run_sorted: assert property (@(posedge clock) disable iff (reset)
         (vld_ff[SORT_STAGES-1] && link_w[k])
            |-> (srt_ff[SORT_STAGES-1][k] >= srt_ff[SORT_STAGES-1][k-1]))
         else $error("run not sorted at dimension %0d", k);
   end

   // unused dimensions always come out as zero
   for (genvar k = 0; k < MAX_DIMS; k++) begin : g_chk_unused
      if (k >= NUM_DIMS) begin : g_on
         a_unused_zero: assert property (@(posedge clock) disable iff (reset)
            rsp_tvalid |-> (out_ff[k] == '0))
            else $error("unused dimension %0d not zero", k);
      end
   end

   // nothing is valid in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (vld_ff == '0))
      else $error("pipeline valid after reset");

endmodule
